>>> design/assert_macros.svh
// Assertion helpers for the divider unit's checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted
`define SBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define SBD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sbd_pkg.sv
package sbd_pkg;

    // Sequencer commands to the shift/subtract datapath
    typedef struct packed {
        logic load;   // take fresh magnitudes, clear partial remainder
        logic step;   // retire one quotient bit
    } sbd_ctrl_t;

endpackage

>>> design/signed_binary_divider_unit.sv
// The shift/subtract loop retires one quotient bit per cycle; after the last bit a fix-up
// state applies the signs and registers the results together with done.
// A new word may start in the cycle done is shown.
// done is high for a single cycle and cannot be held off; results stay until the next word.
// Reset (rst_n, asynchronous, active low) clears the sequencer and the done strobe.
`include "assert_macros.svh"

module signed_binary_divider_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic signed [DATA_WIDTH-1:0] remainder,
    output logic                         divide_by_zero
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  qneg_reg, qneg_next;
    logic                  rneg_reg, rneg_next;
    logic                  zero_reg, zero_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;

    logic                  accept;
    logic [DATA_WIDTH-1:0] dividend_mag, divisor_mag;
    logic [DATA_WIDTH-1:0] quotient_mag, remainder_mag;
    sbd_pkg::sbd_ctrl_t    ctrl;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;

    // Operand magnitudes; the most negative value maps onto itself as unsigned
    assign dividend_mag = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign divisor_mag  = divisor[DATA_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

    // Datapath commands
    always_comb
    begin
        ctrl.load = accept;
        ctrl.step = (state_reg == ST_RUN);
    end

    sbd_shift_sub #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_shift_sub (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .dividend_mag  (dividend_mag),
        .divisor_mag   (divisor_mag),
        .quotient_mag  (quotient_mag),
        .remainder_mag (remainder_mag)
    );

    // Sequencer, sign fix-up and divide-by-zero results
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        qneg_next  = qneg_reg;
        rneg_next  = rneg_reg;
        zero_next  = zero_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    qneg_next  = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
                    rneg_next  = dividend[DATA_WIDTH-1];
                    zero_next  = (divisor == '0);
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (zero_reg)
                begin
                    quo_next = '0;
                    rem_next = '0;
                end
                else
                begin
                    quo_next = qneg_reg ? (~quotient_mag + 1'b1) : quotient_mag;
                    rem_next = rneg_reg ? (~remainder_mag + 1'b1) : remainder_mag;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        zero_reg <= zero_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign done           = done_reg;
    assign quotient       = quo_reg;
    assign remainder      = rem_reg;
    assign divide_by_zero = zero_reg;

    // Checks
    `SBD_ASSERT(a_done_after_fix, clk, rst_n, done |-> $past(state_reg == ST_FIX), "done without fix-up")
    `SBD_ASSERT(a_done_single, clk, rst_n, done |=> !done, "done held past one cycle")
    `SBD_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted word did not start")
    `SBD_ASSERT(a_zero_results, clk, rst_n, (done && divide_by_zero) |-> (quotient == '0 && remainder == '0), "zero divisor gave nonzero results")
    `SBD_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !done, "done during reset")

endmodule

>>> design/sbd_shift_sub.sv
module sbd_shift_sub #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sbd_pkg::sbd_ctrl_t      ctrl,
    input  logic [DATA_WIDTH-1:0]   dividend_mag,
    input  logic [DATA_WIDTH-1:0]   divisor_mag,
    output logic [DATA_WIDTH-1:0]   quotient_mag,
    output logic [DATA_WIDTH-1:0]   remainder_mag
);

    // Partial remainder, dividend/quotient shift register, divisor
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0] dsr_reg, dsr_next;

    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    // Bring in the next dividend bit and trial-subtract the divisor.
    // Unless the divisor is zero, the remainder stays below the divisor, so its top bit is always clear.
    assign shifted = {rem_reg[DATA_WIDTH-2:0], dvd_reg[DATA_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {1'b0, dsr_reg};
    assign fits    = ~diff[DATA_WIDTH];

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        if (ctrl.load)
        begin
            rem_next = '0;
            dvd_next = dividend_mag;
            dsr_next = divisor_mag;
        end
        else if (ctrl.step)
        begin
            rem_next = fits ? diff[DATA_WIDTH-1:0] : shifted;
            dvd_next = {dvd_reg[DATA_WIDTH-2:0], fits};
        end
    end

    // Datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            dvd_reg <= '0;
            dsr_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            dsr_reg <= dsr_next;
        end
    end

    assign quotient_mag  = dvd_reg;
    assign remainder_mag = rem_reg;

endmodule
